### hw/rtl/svdc_pkg.sv
// ----------------------------------------------------------------------------
// svdc_pkg
// types and constants shared by the steam valve duty cycler modules
// ----------------------------------------------------------------------------
package svdc_pkg;

  localparam int unsigned TimeW    = 16;
  localparam int unsigned TicksW   = 20;
  localparam int unsigned StepW    = 6;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 32;
  localparam int unsigned NumRegs  = 6;

  localparam logic [StepW-1:0] PrimeOnEnd   = StepW'(10);
  localparam logic [StepW-1:0] PrimeOffEnd  = StepW'(40);
  localparam logic [StepW-1:0] PrimeOnLimit = StepW'(50);

  typedef enum logic [2:0] {
    CMD_TICK        = 3'd0,
    CMD_SET_LEVEL   = 3'd1,
    CMD_START_PRIME = 3'd2,
    CMD_START_ON    = 3'd3,
    CMD_CLEAR_TIMES = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    LEVEL_NONE   = 2'd0,
    LEVEL_LOW    = 2'd1,
    LEVEL_MEDIUM = 2'd2,
    LEVEL_HIGH   = 2'd3
  } level_e;

  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_PRIME     = 3'd1,
    MODE_OFF_ENTRY = 3'd2,
    MODE_ON_ENTRY  = 3'd3,
    MODE_TIMING    = 3'd4,
    MODE_DEACT     = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_OFF  = 2'd1,
    PH_ON   = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    REG_LOW_ON     = 3'd0,
    REG_LOW_OFF    = 3'd1,
    REG_MEDIUM_ON  = 3'd2,
    REG_MEDIUM_OFF = 3'd3,
    REG_HIGH_ON    = 3'd4,
    REG_HIGH_OFF   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [2:0] command;
    logic [1:0] level;
    logic       pause;
  } item_t;

  typedef struct packed {
    logic              valve_open;
    logic [2:0]        ctrl_state;
    logic [TicksW-1:0] remaining;
    logic              turn_off;
  } result_t;

  typedef struct packed {
    logic [TimeW-1:0] low_on_time;
    logic [TimeW-1:0] low_off_time;
    logic [TimeW-1:0] medium_on_time;
    logic [TimeW-1:0] medium_off_time;
    logic [TimeW-1:0] high_on_time;
    logic [TimeW-1:0] high_off_time;
  } cfg_t;

  // time registers count in tens of ticks
  function automatic logic [TicksW-1:0] scale_time(input logic [TimeW-1:0] t);
    logic [TicksW-1:0] x;
    x = TicksW'(t);
    return (x << 3) + (x << 1);
  endfunction

endpackage

### hw/rtl/svdc_cfg_regs.sv
// ----------------------------------------------------------------------------
// svdc_cfg_regs
// apb register file holding the six on/off time registers
// ----------------------------------------------------------------------------
module svdc_cfg_regs
  import svdc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[AddrW-1:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LOW_ON:     cfg_q.low_on_time     <= pwdata[TimeW-1:0];
        REG_LOW_OFF:    cfg_q.low_off_time    <= pwdata[TimeW-1:0];
        REG_MEDIUM_ON:  cfg_q.medium_on_time  <= pwdata[TimeW-1:0];
        REG_MEDIUM_OFF: cfg_q.medium_off_time <= pwdata[TimeW-1:0];
        REG_HIGH_ON:    cfg_q.high_on_time    <= pwdata[TimeW-1:0];
        REG_HIGH_OFF:   cfg_q.high_off_time   <= pwdata[TimeW-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LOW_ON:     prdata = DataW'(cfg_q.low_on_time);
      REG_LOW_OFF:    prdata = DataW'(cfg_q.low_off_time);
      REG_MEDIUM_ON:  prdata = DataW'(cfg_q.medium_on_time);
      REG_MEDIUM_OFF: prdata = DataW'(cfg_q.medium_off_time);
      REG_HIGH_ON:    prdata = DataW'(cfg_q.high_on_time);
      REG_HIGH_OFF:   prdata = DataW'(cfg_q.high_off_time);
      default:        prdata = '0;
    endcase
  end

endmodule

### hw/rtl/svdc_core.sv
// ----------------------------------------------------------------------------
// svdc_core
// valve sequencer state and its combinational update for one transaction
// ----------------------------------------------------------------------------
module svdc_core
  import svdc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  mode_e             mode_q, mode_d, mode_t;
  phase_e            phase_q, phase_d;
  logic [TicksW-1:0] on_ticks_q, on_ticks_d;
  logic [TicksW-1:0] off_ticks_q, off_ticks_d;
  logic [TicksW-1:0] countdown_q, countdown_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [StepW-1:0]  prime_q, prime_d;
  logic              flag_q, flag_d;
  logic              valve_q, valve_d;
  logic [TimeW-1:0]  sel_on, sel_off;

  always_comb begin
    unique case (item_i.level)
      LEVEL_LOW: begin
        sel_on  = cfg_i.low_on_time;
        sel_off = cfg_i.low_off_time;
      end
      LEVEL_MEDIUM: begin
        sel_on  = cfg_i.medium_on_time;
        sel_off = cfg_i.medium_off_time;
      end
      LEVEL_HIGH: begin
        sel_on  = cfg_i.high_on_time;
        sel_off = cfg_i.high_off_time;
      end
      default: begin
        sel_on  = '0;
        sel_off = '0;
      end
    endcase
  end

  always_comb begin
    mode_d      = mode_q;
    phase_d     = phase_q;
    on_ticks_d  = on_ticks_q;
    off_ticks_d = off_ticks_q;
    countdown_d = countdown_q;
    step_d      = step_q;
    prime_d     = prime_q;
    flag_d      = flag_q;
    valve_d     = valve_q;
    mode_t      = flag_q ? MODE_DEACT : mode_q;

    unique case (item_i.command)
      CMD_TICK: begin
        mode_d = mode_t;
        if (!item_i.pause) begin
          unique case (mode_t)
            MODE_PRIME: begin
              priority if (step_q < PrimeOnEnd) begin
                valve_d = 1'b1;
                step_d  = step_q + 1'b1;
                prime_d = prime_q + 1'b1;
              end else if (step_q <= PrimeOffEnd) begin
                valve_d = 1'b0;
                step_d  = step_q + 1'b1;
              end else begin
                step_d  = '0;
              end
              if (prime_d > PrimeOnLimit) begin
                step_d      = '0;
                prime_d     = '0;
                mode_d      = MODE_ON_ENTRY;
                countdown_d = on_ticks_q;
              end
            end
            MODE_OFF_ENTRY: begin
              valve_d     = 1'b0;
              countdown_d = off_ticks_q;
              mode_d      = MODE_TIMING;
              phase_d     = PH_OFF;
            end
            MODE_ON_ENTRY: begin
              valve_d     = 1'b1;
              countdown_d = on_ticks_q;
              mode_d      = MODE_TIMING;
              phase_d     = PH_ON;
            end
            MODE_TIMING: begin
              // with no previous phase the block stays in timing
              priority if (countdown_q != '0) begin
                countdown_d = countdown_q - 1'b1;
              end else if (phase_q == PH_ON) begin
                mode_d = MODE_OFF_ENTRY;
              end else if (phase_q == PH_OFF) begin
                mode_d = MODE_ON_ENTRY;
              end
            end
            MODE_DEACT: begin
              valve_d = 1'b0;
              phase_d = PH_IDLE;
              mode_d  = MODE_IDLE;
            end
            default: ;
          endcase
        end
      end
      CMD_SET_LEVEL: begin
        on_ticks_d  = scale_time(sel_on);
        off_ticks_d = scale_time(sel_off);
        countdown_d = scale_time(sel_on);
        flag_d      = (sel_on == '0);
      end
      CMD_START_PRIME: mode_d = MODE_PRIME;
      CMD_START_ON:    mode_d = MODE_ON_ENTRY;
      CMD_CLEAR_TIMES: begin
        on_ticks_d  = '0;
        off_ticks_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      phase_q     <= PH_IDLE;
      on_ticks_q  <= '0;
      off_ticks_q <= '0;
      countdown_q <= '0;
      step_q      <= '0;
      prime_q     <= '0;
      flag_q      <= 1'b0;
      valve_q     <= 1'b0;
    end else if (fire_i) begin
      mode_q      <= mode_d;
      phase_q     <= phase_d;
      on_ticks_q  <= on_ticks_d;
      off_ticks_q <= off_ticks_d;
      countdown_q <= countdown_d;
      step_q      <= step_d;
      prime_q     <= prime_d;
      flag_q      <= flag_d;
      valve_q     <= valve_d;
    end
  end

  assign result_o.valve_open = valve_d;
  assign result_o.ctrl_state = mode_d;
  assign result_o.remaining  = countdown_d;
  assign result_o.turn_off   = flag_d;

endmodule

### hw/rtl/steam_valve_duty_cycler.sv
// ----------------------------------------------------------------------------
// steam_valve_duty_cycler
// water inlet valve on/off sequencer with priming and level-selected timing
// ----------------------------------------------------------------------------
// path: input register, combinational state update, result register
// throughput: one transaction per cycle while the result register is free or
//   drained; out_ready_i low with a full result register stalls the input
// reset: rst_ni clears the sequencer state, the time registers and the
//   pipeline valid bits at once; no clearing pass is needed
module steam_valve_duty_cycler
  import svdc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  item_t            in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output result_t          out_result_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t    cfg;
  logic    s1_valid_q;
  item_t   s1_item_q;
  logic    out_valid_q;
  result_t out_result_q;
  result_t result_d;
  logic    s1_fire;

  // the input stage moves on whenever the result register is free or drained
  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;

  svdc_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  svdc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (s1_fire),
    .item_i   (s1_item_q),
    .cfg_i    (cfg),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_item_i;
    end
    if (s1_fire) begin
      out_result_q <= result_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_result_q;

endmodule
